[hdl/pest_pkg.sv]
// Shared types and constants of the periodic event slot ticker.
// No dependencies; imported by every module of the block.
package pest_pkg;

    localparam int NREG_SLOTS  = 4;   // sets of slot registers in the config map
    localparam int MAX_EVENTS  = 16;  // events one poll may publish at most
    localparam int SLOTS_DEF   = 4;
    localparam int CATCHUP_DEF = 4;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 31;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_POLL  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_EVENT     = 2'd0,
        KIND_POLL_DONE = 2'd1,
        KIND_DROP      = 2'd2,
        KIND_START     = 2'd3
    } t_kind;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ACTIVE  = 3'd0,
        CFG_PERIOD0 = 3'd1,
        CFG_PERIOD1 = 3'd2,
        CFG_PERIOD2 = 3'd3,
        CFG_PERIOD3 = 3'd4,
        CFG_CODES   = 3'd5
    } t_cfg_idx;

    // Operand request to the shared adder/subtractor.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } t_alu_req;

endpackage

[hdl/pest_alu.sv]
// Shared 32-bit adder/subtractor used by the slot sequencer.
// Depends on pest_pkg for the request struct.
module pest_alu
    import pest_pkg::*;
(
    input  t_alu_req    i_req,
    output logic [31:0] o_sum
);

    logic [31:0] w_b;

    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum = i_req.a + w_b + 32'(i_req.sub);

endmodule

[hdl/periodic_event_slot_ticker_top.sv]
// Channel  | dir | handshake                  | payload
// input    | in  | i_s_tvalid / o_s_tready    | i_s_tdata, i_s_tuser
// result   | out | o_m_tvalid / i_m_tready    | o_m_tdata, o_m_tuser, o_m_tlast
// config   | in  | i_cfg_wr_en (no wait)      | i_cfg_addr, i_cfg_wdata
//
// One item at a time; each deadline add, drop increment and deadline compare
// goes through one shared 32-bit adder. Start writes every slot in turn; read
// and early poll answer directly. Poll visits each active slot: an event is a
// check and an advance, a drop is a check, increment and advance, and a miss
// or rebase ends a slot. A result that waits on i_m_tready stalls the sequencer.
// Reset (synchronous, i_rst_n low) clears the sequencer, the started flag,
// the active count and codes, sets each period to 1; no clearing pass is needed.
// Top level of the ticker; depends on pest_pkg and pest_alu.
module periodic_event_slot_ticker_top
    import pest_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int CATCHUP = CATCHUP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // now_ticks[31:0], queue_space[39:32], slot_select[43:40], zero fill
    input  logic [47:0]       i_s_tdata,
    // mode[1:0]
    input  logic [1:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // slot_number[1:0], slot_type[5:2], event_priority[7:6],
    // published_count[12:8], drop_count[44:13], zero fill
    output logic [47:0]       o_m_tdata,
    // kind[1:0], not_started[2]
    output logic [2:0]        o_m_tuser,
    output logic              o_m_tlast,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int CW       = $clog2(SLOTS + 1);
    localparam int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW       = $clog2(CATCHUP + 1);
    localparam int LIVE_MAX = (SLOTS < NREG_SLOTS) ? SLOTS : NREG_SLOTS;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_START  = 10'b00_0000_0010,
        ST_ACK    = 10'b00_0000_0100,
        ST_NSTART = 10'b00_0000_1000,
        ST_READ   = 10'b00_0001_0000,
        ST_CHK    = 10'b00_0010_0000,
        ST_DROP   = 10'b00_0100_0000,
        ST_ADV    = 10'b00_1000_0000,
        ST_REBASE = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } t_state;

    // Configuration registers
    logic [2:0]  r_active;
    logic [30:0] r_period [NREG_SLOTS];
    logic [23:0] r_codes;

    // Slot state
    logic [31:0] r_deadline [SLOTS];
    logic [31:0] r_drop     [SLOTS];

    // Sequencer
    t_state      r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [KW-1:0] r_cnt, n_cnt;
    logic        r_brk, n_brk;
    logic [4:0]  r_space, n_space;
    logic [4:0]  r_pub, n_pub;
    logic        r_started, n_started;
    logic [31:0] r_now;
    logic        r_rd_ok;

    // Output register
    logic        r_out_valid;
    t_kind       r_o_kind;
    logic [1:0]  r_o_slot;
    logic [3:0]  r_o_type;
    logic [1:0]  r_o_prio;
    logic [4:0]  r_o_pub;
    logic [31:0] r_o_drop;
    logic        r_o_ns;
    logic        r_o_last;

    logic        w_load;
    t_kind       w_o_kind;
    logic [1:0]  w_o_slot;
    logic [3:0]  w_o_type;
    logic [1:0]  w_o_prio;
    logic [4:0]  w_o_pub;
    logic [31:0] w_o_drop;
    logic        w_o_ns;

    logic        w_dl_we, w_drop_we;
    logic [31:0] w_dl_wdata, w_drop_wdata;

    t_alu_req    w_alu_req;
    logic [31:0] w_sum;

    logic        w_s_fire, w_out_free;
    logic [2:0]  w_live;
    logic [1:0]  w_ridx;
    logic [IW-1:0] w_aidx;
    logic [31:0] w_per;
    logic [5:0]  w_code;
    logic [31:0] w_cur_dl, w_cur_drop;
    logic        w_in_live, w_slot_last, w_sweep_last, w_reached;
    logic [7:0]  w_in_space;
    logic [3:0]  w_in_sel;

    assign w_s_fire   = i_s_tvalid & o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_in_space = i_s_tdata[39:32];
    assign w_in_sel   = i_s_tdata[43:40];

    assign w_live     = (r_active > 3'(LIVE_MAX)) ? 3'(LIVE_MAX) : r_active;
    assign w_ridx     = 2'(r_idx);
    assign w_aidx     = r_idx[IW-1:0];
    assign w_per      = (r_period[w_ridx] == '0) ? 32'd1 : {1'b0, r_period[w_ridx]};
    assign w_code     = r_codes[w_ridx*6 +: 6];
    assign w_cur_dl   = r_deadline[w_aidx];
    assign w_cur_drop = r_drop[w_aidx];

    assign w_in_live    = 5'(r_idx) < 5'(w_live);
    assign w_slot_last  = (5'(r_idx) + 5'd1) == 5'(w_live);
    assign w_sweep_last = 5'(r_idx) == 5'(SLOTS - 1);
    // The deadline is reached when now minus deadline is not negative.
    assign w_reached    = !w_sum[31];

    // Operand selection for the shared adder.
    always_comb begin
        w_alu_req = '0;
        unique case (r_state)
            ST_START, ST_REBASE: begin
                w_alu_req.a = r_now;
                w_alu_req.b = w_per;
            end
            ST_CHK: begin
                w_alu_req.a   = r_now;
                w_alu_req.b   = w_cur_dl;
                w_alu_req.sub = 1'b1;
            end
            ST_DROP: begin
                w_alu_req.a = w_cur_drop;
                w_alu_req.b = 32'd1;
            end
            ST_ADV: begin
                w_alu_req.a = w_cur_dl;
                w_alu_req.b = w_per;
            end
            default: w_alu_req = '0;
        endcase
    end

    pest_alu u_alu (
        .i_req (w_alu_req),
        .o_sum (w_sum)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_brk        = r_brk;
        n_space      = r_space;
        n_pub        = r_pub;
        n_started    = r_started;
        w_load       = 1'b0;
        w_o_kind     = KIND_START;
        w_o_slot     = '0;
        w_o_type     = '0;
        w_o_prio     = '0;
        w_o_pub      = '0;
        w_o_drop     = '0;
        w_o_ns       = 1'b0;
        w_dl_we      = 1'b0;
        w_dl_wdata   = w_sum;
        w_drop_we    = 1'b0;
        w_drop_wdata = w_sum;

        unique case (r_state)
            ST_IDLE: begin
                if (w_s_fire) begin
                    unique case (t_mode'(i_s_tuser))
                        MODE_START: begin
                            n_idx   = '0;
                            n_state = ST_START;
                        end
                        MODE_POLL: begin
                            n_space = (w_in_space > 8'(MAX_EVENTS)) ?
                                      5'(MAX_EVENTS) : 5'(w_in_space);
                            n_pub   = '0;
                            n_idx   = '0;
                            n_cnt   = '0;
                            n_brk   = 1'b0;
                            if (!r_started) begin
                                n_state = ST_NSTART;
                            end else if (w_live == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_CHK;
                            end
                        end
                        MODE_READ: begin
                            n_idx   = CW'(w_in_sel);
                            n_state = ST_READ;
                        end
                        MODE_NONE: n_state = ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: begin
                w_dl_we      = 1'b1;
                w_dl_wdata   = w_in_live ? w_sum : 32'd0;
                w_drop_we    = 1'b1;
                w_drop_wdata = 32'd0;
                if (w_sweep_last) begin
                    n_started = 1'b1;
                    n_state   = ST_ACK;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_ACK: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_NSTART: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_o_ns  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    w_o_kind = KIND_DROP;
                    w_o_drop = r_rd_ok ? w_cur_drop : 32'd0;
                    n_state  = ST_IDLE;
                end
            end
            ST_CHK: begin
                if (!w_reached) begin
                    if (w_slot_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_cnt   = '0;
                        n_brk   = 1'b0;
                        n_state = ST_CHK;
                    end
                end else if (r_brk || r_cnt == KW'(CATCHUP)) begin
                    n_state = ST_REBASE;
                end else if (r_space == '0) begin
                    n_state = ST_DROP;
                end else if (w_out_free) begin
                    w_load   = 1'b1;
                    w_o_kind = KIND_EVENT;
                    w_o_slot = w_ridx;
                    w_o_type = w_code[3:0];
                    w_o_prio = w_code[5:4];
                    n_space  = r_space - 5'd1;
                    n_pub    = r_pub + 5'd1;
                    n_cnt    = r_cnt + KW'(1);
                    n_state  = ST_ADV;
                end
            end
            ST_DROP: begin
                // Saturating increment; a full queue ends catch-up for this slot.
                w_drop_we = (w_cur_drop != '1);
                n_brk     = 1'b1;
                n_state   = ST_ADV;
            end
            ST_ADV: begin
                w_dl_we = 1'b1;
                n_state = ST_CHK;
            end
            ST_REBASE: begin
                w_dl_we = 1'b1;
                if (w_slot_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_cnt   = '0;
                    n_brk   = 1'b0;
                    n_state = ST_CHK;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    w_o_kind = KIND_POLL_DONE;
                    w_o_pub  = r_pub;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_brk       <= 1'b0;
            r_space     <= '0;
            r_pub       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_codes     <= '0;
            for (int i = 0; i < NREG_SLOTS; i++) begin
                r_period[i] <= 31'd1;
            end
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_brk     <= n_brk;
            r_space   <= n_space;
            r_pub     <= n_pub;
            r_started <= n_started;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_ACTIVE:  r_active    <= i_cfg_wdata[2:0];
                    CFG_PERIOD0: r_period[0] <= i_cfg_wdata;
                    CFG_PERIOD1: r_period[1] <= i_cfg_wdata;
                    CFG_PERIOD2: r_period[2] <= i_cfg_wdata;
                    CFG_PERIOD3: r_period[3] <= i_cfg_wdata;
                    CFG_CODES:   r_codes     <= i_cfg_wdata[23:0];
                    default:     r_active    <= r_active;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_now   <= i_s_tdata[31:0];
            r_rd_ok <= r_started && (5'(w_in_sel) < 5'(w_live));
        end
        if (w_dl_we) begin
            r_deadline[w_aidx] <= w_dl_wdata;
        end
        if (w_drop_we) begin
            r_drop[w_aidx] <= w_drop_wdata;
        end
        if (w_load) begin
            r_o_kind <= w_o_kind;
            r_o_slot <= w_o_slot;
            r_o_type <= w_o_type;
            r_o_prio <= w_o_prio;
            r_o_pub  <= w_o_pub;
            r_o_drop <= w_o_drop;
            r_o_ns   <= w_o_ns;
            r_o_last <= (w_o_kind != KIND_EVENT);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_o_drop, r_o_pub, r_o_prio, r_o_type, r_o_slot};
    assign o_m_tuser  = {r_o_ns, r_o_kind};
    assign o_m_tlast  = r_o_last;

endmodule

[hdl/pest_checker.sv]
// Port-level checks of the periodic event slot ticker, bound to the top level.
// Depends on pest_pkg and periodic_event_slot_ticker_top.
module pest_checker
    import pest_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [1:0]        i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [47:0]       o_m_tdata,
    input logic [2:0]        o_m_tuser,
    input logic              o_m_tlast
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Events never close an input's results; every other kind does.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser[1:0] != KIND_EVENT)))
        else $error("tlast does not match result kind");

    // The not-started flag only appears on a start-kind final result.
    a_not_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tuser[1:0] == KIND_START && o_m_tlast)
        else $error("not_started on a wrong result");

    // An accepted command other than MODE_NONE keeps the block busy in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser != MODE_NONE |=> !o_s_tready)
        else $error("input accepted again while busy");

endmodule

bind periodic_event_slot_ticker_top pest_checker u_pest_checker (.*);
